// File: rtl/best_offset_prefetcher_macros.svh
// ----------------------------------------------------------------------------
// Best-offset prefetcher assertion macros
// Shared concurrent assertion forms on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef BEST_OFFSET_PREFETCHER_MACROS_SVH
`define BEST_OFFSET_PREFETCHER_MACROS_SVH

// same-cycle implication
`define BOP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bop assertion failed");

// next-cycle implication
`define BOP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bop assertion failed");

`endif

// File: rtl/bop_pkg.sv
// ----------------------------------------------------------------------------
// Best-offset prefetcher package
// Sizes, codes and shared types of the prefetcher.
// ----------------------------------------------------------------------------
package bop_pkg;

   localparam int ADDR_BITS    = 48;
   localparam int INDEX_BITS   = 8;
   localparam int OFFSET_COUNT = 32;
   localparam int TABLE_SIZE   = 1 << INDEX_BITS;
   localparam int OIDX_BITS    = $clog2(OFFSET_COUNT);
   localparam int CAND_BITS    = $clog2(OFFSET_COUNT + 1);
   localparam int SCORE_BITS   = 5;
   localparam int ROUND_BITS   = 8;
   localparam int FQ_DEPTH     = 2;
   localparam int FQ_PTR_BITS  = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_BITS  = $clog2(FQ_DEPTH + 1);
   localparam int RQ_DEPTH     = 2;
   localparam int RQ_PTR_BITS  = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_BITS  = $clog2(RQ_DEPTH + 1);
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 8;

   localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
   localparam logic [ROUND_BITS-1:0] ROUND_MAX = '1;

   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_FILL  = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCK_LOG2 = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SAME_PAGE  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAGE_LOG2  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROUND_LIM  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCORE_LIM  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BAD_LIM    = 3'd5;

   typedef enum logic {
      OP_READ,
      OP_FILL
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [ADDR_BITS-1:0]   addr;
      logic                   was_pf;
   } item_type;

   typedef struct packed {
      logic [3:0]             block_bytes_log2;
      logic                   check_same_page;
      logic [4:0]             page_bytes_log2;
      logic [ROUND_BITS-1:0]  round_limit;
      logic [SCORE_BITS-1:0]  score_limit;
      logic [SCORE_BITS-1:0]  bad_score_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_WRITE,
      ST_READ,
      ST_TRAIN,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/best_offset_prefetcher.sv
// ----------------------------------------------------------------------------
// Best-offset prefetcher
// Learns a block offset from recent fills and issues prefetch addresses.
// ----------------------------------------------------------------------------
// Input side is a queue: an item (read, write or fill) enters when push is
// high and full is low. Writes, reads without a PC and unused request codes
// are dropped at the door. Results leave through a second queue: while empty
// is low, rsp_prefetch_addr holds the oldest prefetch address, taken by pop.
// A two-entry queue sits between the front end and the sequencer, so the
// input keeps flowing while the sequencer is busy or the output is stalled.
// On a read the sequencer steps through pick-up, address calc, table read,
// score update and issue; on a fill through pick-up, address calc and table
// write. The single-port recent table sets these steps. When the result
// queue has no free entry the sequencer waits, the inner queue fills and
// full rises. Reset empties both queues, clears the recent table valid bits
// and training state, and turns prefetching off; csr registers go to their
// defaults. Registers are written through csr_write_en/csr_index/csr_wdata.
// ----------------------------------------------------------------------------
module best_offset_prefetcher import bop_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [1:0]               req_type,
   input  logic [ADDR_BITS-1:0]     req_addr,
   input  logic                     req_has_pc,
   input  logic                     req_fill_was_prefetch,
   output logic                     empty,
   input  logic                     pop,
   output logic [ADDR_BITS-1:0]     rsp_prefetch_addr,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

`include "best_offset_prefetcher_macros.svh"

   cfg_type                 cfg_ff;
   logic                    q_valid;
   item_type                q_item;
   logic                    q_pop;
   logic                    back_push;
   logic [ADDR_BITS-1:0]    back_addr;
   logic [ADDR_BITS-1:0]    rsp_mem_ff [RQ_DEPTH];
   logic [RQ_PTR_BITS-1:0]  rsp_wr_ff, rsp_wr_in;
   logic [RQ_PTR_BITS-1:0]  rsp_rd_ff, rsp_rd_in;
   logic [RQ_CNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                    rsp_pop;
   logic                    out_space;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_bytes_log2 <= 4'd6;
         cfg_ff.check_same_page  <= 1'b0;
         cfg_ff.page_bytes_log2  <= 5'd12;
         cfg_ff.round_limit      <= 8'd100;
         cfg_ff.score_limit      <= 5'd31;
         cfg_ff.bad_score_limit  <= 5'd1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BLOCK_LOG2: cfg_ff.block_bytes_log2 <= csr_wdata[3:0];
            CSR_SAME_PAGE:  cfg_ff.check_same_page  <= csr_wdata[0];
            CSR_PAGE_LOG2:  cfg_ff.page_bytes_log2  <= csr_wdata[4:0];
            CSR_ROUND_LIM:  cfg_ff.round_limit      <= csr_wdata[ROUND_BITS-1:0];
            CSR_SCORE_LIM:  cfg_ff.score_limit      <= csr_wdata[SCORE_BITS-1:0];
            CSR_BAD_LIM:    cfg_ff.bad_score_limit  <= csr_wdata[SCORE_BITS-1:0];
            default: ;
         endcase
      end
   end

   bop_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_type              (req_type),
      .req_addr              (req_addr),
      .req_has_pc            (req_has_pc),
      .req_fill_was_prefetch (req_fill_was_prefetch),
      .q_valid               (q_valid),
      .q_item                (q_item),
      .q_pop                 (q_pop)
   );

   bop_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .out_space (out_space),
      .out_push  (back_push),
      .out_addr  (back_addr)
   );

   // result queue; a slot is reserved when the sequencer picks up an item
   assign out_space         = (rsp_count_ff != RQ_CNT_BITS'(RQ_DEPTH));
   assign empty             = (rsp_count_ff == '0);
   assign rsp_prefetch_addr = rsp_mem_ff[rsp_rd_ff];

   always_comb begin
      rsp_pop   = pop && !empty;
      rsp_wr_in = rsp_wr_ff;
      rsp_rd_in = rsp_rd_ff;
      if (back_push) begin
         rsp_wr_in = (rsp_wr_ff == RQ_PTR_BITS'(RQ_DEPTH - 1)) ? '0 : rsp_wr_ff + 1'b1;
      end
      if (rsp_pop) begin
         rsp_rd_in = (rsp_rd_ff == RQ_PTR_BITS'(RQ_DEPTH - 1)) ? '0 : rsp_rd_ff + 1'b1;
      end
      rsp_count_in = rsp_count_ff + RQ_CNT_BITS'(back_push) - RQ_CNT_BITS'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ff    <= '0;
         rsp_rd_ff    <= '0;
         rsp_count_ff <= '0;
      end else begin
         rsp_wr_ff    <= rsp_wr_in;
         rsp_rd_ff    <= rsp_rd_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (back_push) begin
         rsp_mem_ff[rsp_wr_ff] <= back_addr;
      end
   end

   `BOP_ASSERT_IMP(a_rsp_no_overflow, back_push, rsp_count_ff != RQ_CNT_BITS'(RQ_DEPTH))
   `BOP_ASSERT_IMP(a_rsp_count_bound, 1'b1, rsp_count_ff <= RQ_CNT_BITS'(RQ_DEPTH))
   `BOP_ASSERT_NXT(a_rsp_stays_empty, empty && !back_push, empty)
   `BOP_ASSERT_IMP(a_pop_needs_space, q_pop, out_space && q_valid)

endmodule

// File: rtl/bop_front.sv
// ----------------------------------------------------------------------------
// Best-offset prefetcher front end
// Accepts requests, drops those with no effect, queues reads and fills.
// ----------------------------------------------------------------------------
module bop_front import bop_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [1:0]           req_type,
   input  logic [ADDR_BITS-1:0] req_addr,
   input  logic                 req_has_pc,
   input  logic                 req_fill_was_prefetch,
   output logic                 q_valid,
   output item_type             q_item,
   input  logic                 q_pop
);

   item_type               queue_ff [FQ_DEPTH];
   logic [FQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FQ_CNT_BITS-1:0] count_ff, count_in;
   logic                   keep;
   logic                   wr_en;
   logic                   rd_en;
   item_type               new_item;

   assign full    = (count_ff == FQ_CNT_BITS'(FQ_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = queue_ff[rd_ptr_ff];

   // writes and reads without a PC never reach the back end
   always_comb begin
      keep = (req_type == REQ_FILL) || ((req_type == REQ_READ) && req_has_pc);
      new_item.op     = (req_type == REQ_FILL) ? OP_FILL : OP_READ;
      new_item.addr   = req_addr;
      new_item.was_pf = req_fill_was_prefetch;
      wr_en = push && !full && keep;
      rd_en = q_pop && q_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == FQ_PTR_BITS'(FQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == FQ_PTR_BITS'(FQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + FQ_CNT_BITS'(wr_en) - FQ_CNT_BITS'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: rtl/bop_back.sv
// ----------------------------------------------------------------------------
// Best-offset prefetcher back end
// Sequencer over the recent table, offset training and prefetch issue.
// ----------------------------------------------------------------------------
module bop_back import bop_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 q_valid,
   input  item_type             q_item,
   output logic                 q_pop,
   input  logic                 out_space,
   output logic                 out_push,
   output logic [ADDR_BITS-1:0] out_addr
);

   state_type               state_ff, state_in;
   item_type                item_ff;
   logic [ADDR_BITS-1:0]    probe_ff;
   logic                    page_ok_ff;
   logic [ADDR_BITS-1:0]    recent_mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0]   valid_ff;
   logic [ADDR_BITS-1:0]    rd_data_ff;
   logic                    rd_valid_ff;

   logic [SCORE_BITS-1:0]   scores_ff [OFFSET_COUNT];
   logic [OIDX_BITS-1:0]    idx_ff;
   logic [ROUND_BITS-1:0]   round_ff;
   logic [CAND_BITS-1:0]    best_ff;
   logic [SCORE_BITS-1:0]   best_score_ff;
   logic [CAND_BITS-1:0]    chosen_ff;
   logic                    off_ff;

   logic [ADDR_BITS-1:0]    blk_mask;
   logic [ADDR_BITS-1:0]    cand_span;
   logic [ADDR_BITS-1:0]    chosen_span;
   logic [ADDR_BITS-1:0]    diff;
   logic [ADDR_BITS-1:0]    calc_addr;
   logic                    calc_ok;
   logic [INDEX_BITS-1:0]   probe_slot;
   logic [CAND_BITS-1:0]    cand;
   logic                    hit;
   logic [SCORE_BITS-1:0]   score_new;
   logic                    better;
   logic [CAND_BITS-1:0]    best_new;
   logic [SCORE_BITS-1:0]   best_score_new;
   logic [OIDX_BITS-1:0]    idx_new;
   logic [ROUND_BITS-1:0]   round_new;
   logic                    done;
   logic [ADDR_BITS-1:0]    target;
   logic                    target_ok;

   function automatic logic same_page(input cfg_type c, input logic [ADDR_BITS-1:0] a,
                                      input logic [ADDR_BITS-1:0] b);
      logic eq;
      eq = ((a >> c.page_bytes_log2) == (b >> c.page_bytes_log2));
      return !c.check_same_page || eq;
   endfunction

   always_comb begin
      blk_mask    = ~((ADDR_BITS'(1) << cfg.block_bytes_log2) - ADDR_BITS'(1));
      cand        = CAND_BITS'(idx_ff) + CAND_BITS'(1);
      cand_span   = ADDR_BITS'(cand) << cfg.block_bytes_log2;
      chosen_span = ADDR_BITS'(chosen_ff) << cfg.block_bytes_log2;
      // a fill stores its own line while off, else (if prefetched and in page) the line the offset came from
      if (item_ff.op == OP_FILL) begin
         diff    = off_ff ? item_ff.addr : item_ff.addr - chosen_span;
         calc_ok = off_ff || (item_ff.was_pf && same_page(cfg, diff, item_ff.addr));
      end else begin
         diff    = item_ff.addr - cand_span;
         calc_ok = 1'b1;
      end
      calc_addr  = diff & blk_mask;
      probe_slot = probe_ff[INDEX_BITS-1:0] ^ probe_ff[2*INDEX_BITS-1:INDEX_BITS];

      hit = rd_valid_ff ? (rd_data_ff == probe_ff) : (probe_ff == '0);
      score_new = (hit && (scores_ff[idx_ff] != SCORE_MAX)) ?
                  scores_ff[idx_ff] + 1'b1 : scores_ff[idx_ff];
      better         = (score_new > best_score_ff);
      best_new       = better ? cand : best_ff;
      best_score_new = better ? score_new : best_score_ff;
      round_new = round_ff;
      if (idx_ff == OIDX_BITS'(OFFSET_COUNT - 1)) begin
         idx_new = '0;
         if (round_ff != ROUND_MAX) begin
            round_new = round_ff + 1'b1;
         end
      end else begin
         idx_new = idx_ff + 1'b1;
      end
      done = !((round_new < cfg.round_limit) && (best_score_new < cfg.score_limit));

      target    = item_ff.addr + chosen_span;
      target_ok = same_page(cfg, item_ff.addr, target);
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      out_push = 1'b0;
      out_addr = target;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_space) begin
               q_pop    = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC:  state_in = (item_ff.op == OP_FILL) ? ST_WRITE : ST_READ;
         ST_WRITE: state_in = ST_IDLE;
         ST_READ:  state_in = ST_TRAIN;
         ST_TRAIN: state_in = ST_EMIT;
         ST_EMIT: begin
            out_push = !off_ff && target_ok;
            state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (state_ff == ST_CALC) begin
         probe_ff   <= calc_addr;
         page_ok_ff <= calc_ok;
      end
   end

   // recent table: registered read, entries never written read as zero
   always_ff @(posedge clock) begin
      if ((state_ff == ST_WRITE) && page_ok_ff) begin
         recent_mem[probe_slot] <= probe_ff;
      end
      rd_data_ff <= recent_mem[probe_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[probe_slot];
         if ((state_ff == ST_WRITE) && page_ok_ff) begin
            valid_ff[probe_slot] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OFFSET_COUNT; i++) begin
            scores_ff[i] <= '0;
         end
         idx_ff        <= '0;
         round_ff      <= '0;
         best_ff       <= '0;
         best_score_ff <= '0;
         chosen_ff     <= '0;
         off_ff        <= 1'b1;
      end else if (state_ff == ST_TRAIN) begin
         if (done) begin
            for (int i = 0; i < OFFSET_COUNT; i++) begin
               scores_ff[i] <= '0;
            end
            idx_ff        <= '0;
            round_ff      <= '0;
            best_ff       <= '0;
            best_score_ff <= '0;
            if (best_score_new <= cfg.bad_score_limit) begin
               off_ff <= 1'b1;
            end else begin
               off_ff    <= 1'b0;
               chosen_ff <= best_new;
            end
         end else begin
            scores_ff[idx_ff] <= score_new;
            idx_ff        <= idx_new;
            round_ff      <= round_new;
            best_ff       <= best_new;
            best_score_ff <= best_score_new;
         end
      end
   end

endmodule

// File: sim/tb_best_offset_prefetcher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Best-offset prefetcher testbench
// Drives reads, writes and fills through the request queue under several
// register settings, predicts each prefetch address with a cycle-free copy
// of the training logic and compares every popped result in order.
// ----------------------------------------------------------------------------
module tb_best_offset_prefetcher;
   import bop_pkg::*;

   localparam logic [1:0]  REQ_UNUSED = 2'd3;
   localparam logic [63:0] ADDR_MASK  = (64'd1 << ADDR_BITS) - 64'd1;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          DRAIN_CYCLES = 40;

   typedef struct {
      logic [1:0]           kind;
      logic [ADDR_BITS-1:0] addr;
      logic                 has_pc;
      logic                 was_pf;
   } req_item_type;

   class bop_scoreboard_type;
      logic [3:0]           blk_log2;
      logic                 same_page;
      logic [4:0]           page_log2;
      logic [7:0]           round_lim;
      logic [4:0]           score_lim;
      logic [4:0]           bad_lim;
      logic [ADDR_BITS-1:0] recent [TABLE_SIZE];
      int                   score [OFFSET_COUNT];
      int                   test_idx, rounds, best_cand, best_score, chosen;
      bit                   pf_off;
      logic [ADDR_BITS-1:0] expected_addrs [$];
      int                   errors;

      function new();
         blk_log2 = 6; same_page = 0; page_log2 = 12;
         round_lim = 100; score_lim = 31; bad_lim = 1;
         foreach (recent[i]) recent[i] = '0;
         restart();
         chosen = 0;
         pf_off = 1;
         errors = 0;
      endfunction

      function void restart();
         foreach (score[i]) score[i] = 0;
         test_idx = 0; rounds = 0; best_cand = 0; best_score = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] v);
         case (idx)
            CSR_BLOCK_LOG2: blk_log2  = v[3:0];
            CSR_SAME_PAGE:  same_page = v[0];
            CSR_PAGE_LOG2:  page_log2 = v[4:0];
            CSR_ROUND_LIM:  round_lim = v;
            CSR_SCORE_LIM:  score_lim = v[4:0];
            CSR_BAD_LIM:    bad_lim   = v[4:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] align(logic [63:0] a);
         return a & ~((64'd1 << blk_log2) - 64'd1) & ADDR_MASK;
      endfunction

      function int slot(logic [63:0] p);
         return int'((p ^ (p >> INDEX_BITS)) & (TABLE_SIZE - 1));
      endfunction

      function bit in_page(logic [63:0] a, logic [63:0] b);
         if (!same_page) return 1;
         return (a >> page_log2) == (b >> page_log2);
      endfunction

      function logic [63:0] span(int off);
         return 64'(off) << blk_log2;
      endfunction

      function void train(logic [63:0] a);
         int          idx;
         logic [63:0] probe;
         idx = test_idx;
         probe = align(a - span(idx + 1));
         if (recent[slot(probe)] == probe[ADDR_BITS-1:0] && score[idx] < 31) score[idx]++;
         if (score[idx] > best_score) begin
            best_cand = idx + 1;
            best_score = score[idx];
         end
         idx++;
         if (idx >= OFFSET_COUNT) begin
            idx = 0;
            if (rounds < 255) rounds++;
         end
         test_idx = idx;
         if (rounds < round_lim && best_score < score_lim) return;
         if (best_score <= bad_lim) begin
            pf_off = 1;
         end else begin
            pf_off = 0;
            chosen = best_cand;
         end
         restart();
      endfunction

      function void note_request(req_item_type it);
         logic [63:0] a, base, target;
         a = 64'(it.addr);
         if (it.kind == REQ_FILL) begin
            if (pf_off) begin
               base = align(a);
               recent[slot(base)] = base[ADDR_BITS-1:0];
            end else if (it.was_pf) begin
               base = (a - span(chosen)) & ADDR_MASK;
               if (in_page(base, a)) begin
                  base = align(base);
                  recent[slot(base)] = base[ADDR_BITS-1:0];
               end
            end
            return;
         end
         if (it.kind != REQ_READ || !it.has_pc) return;
         train(a);
         if (pf_off) return;
         target = (a + span(chosen)) & ADDR_MASK;
         if (!in_page(a, target)) return;
         expected_addrs.insert(expected_addrs.size(), target[ADDR_BITS-1:0]);
      endfunction

      function void check_prefetch(logic [ADDR_BITS-1:0] got);
         logic [ADDR_BITS-1:0] want;
         if (expected_addrs.size() == 0) begin
            $error("prefetch_addr expected none actual %h", got);
            errors++;
            return;
         end
         want = expected_addrs.pop_front();
         if (got !== want) begin
            $error("prefetch_addr expected %h actual %h", want, got);
            errors++;
         end
      endfunction
   endclass

   logic                     clock, reset;
   logic                     push, full, empty, pop;
   logic [1:0]               req_type;
   logic [ADDR_BITS-1:0]     req_addr;
   logic                     req_has_pc, req_fill_was_prefetch;
   logic [ADDR_BITS-1:0]     rsp_prefetch_addr;
   logic                     csr_write_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   bop_scoreboard_type sb;
   bit            quiet;      // no idling on either side
   bit            hold_req;   // ask the receiver for one long stall
   int            cycles;

   best_offset_prefetcher dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[best_offset_prefetcher] ERROR");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && pop && !empty) sb.check_prefetch(rsp_prefetch_addr);

   // receiver: random pop bursts, one long hold on request
   initial begin
      pop = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            pop <= 0;
            repeat (400) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            pop <= 0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clock);
         end else begin
            pop <= 1;
         end
      end
   end

   task automatic send(req_item_type it);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         push <= 0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      push <= 1;
      req_type <= it.kind;
      req_addr <= it.addr;
      req_has_pc <= it.has_pc;
      req_fill_was_prefetch <= it.was_pf;
      do @(posedge clock); while (full);
      sb.note_request(it);
   endtask

   task automatic drain();
      @(negedge clock);
      push <= 0;
      while (sb.expected_addrs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] v);
      @(negedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic set_config(int blk, int sp, int pg, int rl, int sl, int bl);
      csr_write(CSR_BLOCK_LOG2, 8'(blk));
      csr_write(CSR_SAME_PAGE, 8'(sp));
      csr_write(CSR_PAGE_LOG2, 8'(pg));
      csr_write(CSR_ROUND_LIM, 8'(rl));
      csr_write(CSR_SCORE_LIM, 8'(sl));
      csr_write(CSR_BAD_LIM, 8'(bl));
   endtask

   function automatic logic [ADDR_BITS-1:0] rand_addr();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic send_one(logic [1:0] k, logic [ADDR_BITS-1:0] a, logic pc, logic pf);
      req_item_type it;
      it.kind = k; it.addr = a; it.has_pc = pc; it.was_pf = pf;
      send(it);
   endtask

   // fills over a run of blocks, then reads a few blocks ahead so offsets score
   task automatic train_burst(inout int sent);
      logic [63:0] base, blk;
      int          nf, nr, d;
      blk = 64'd1 << sb.blk_log2;
      case ($urandom_range(0, 3))
         0: base = 64'(rand_addr());
         1: base = ((64'(rand_addr()) >> sb.page_log2) << sb.page_log2) - 4 * blk;
         2: base = ADDR_MASK - 6 * blk;
         default: base = 64'($urandom_range(0, 4095)) * blk;
      endcase
      nf = $urandom_range(4, 16);
      nr = $urandom_range(8, 40);
      d = $urandom_range(1, 8);
      for (int k = 0; k < nf; k++) begin
         send_one(REQ_FILL, 48'(base + k * blk + ($urandom & (blk - 1))),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         sent++;
      end
      for (int j = 0; j < nr; j++) begin
         if ($urandom_range(0, 5) == 0)
            send_one(REQ_FILL, 48'(base + (j + d) * blk), 1'b1, 1'b1);
         else
            send_one(REQ_READ, 48'(base + (j + d) * blk + ($urandom & (blk - 1))),
                     $urandom_range(0, 15) != 0, 1'($urandom_range(0, 1)));
         sent++;
      end
   endtask

   task automatic random_phase(int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 2) begin
            send_one(2'($urandom), rand_addr(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            sent++;
         end else begin
            train_burst(sent);
         end
      end
   endtask

   initial begin
      sb = new();
      quiet = 0;
      hold_req = 0;
      cycles = 0;
      reset = 1;
      push = 0;
      req_type = REQ_READ;
      req_addr = '0;
      req_has_pc = 0;
      req_fill_was_prefetch = 0;
      csr_write_en = 0;
      csr_index = CSR_BLOCK_LOG2;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes and dropped request kinds at reset settings
      send_one(REQ_FILL, '0, 1'b0, 1'b0);
      send_one(REQ_FILL, '1, 1'b1, 1'b1);
      send_one(REQ_WRITE, 48'h40, 1'b1, 1'b0);
      send_one(REQ_UNUSED, '1, 1'b1, 1'b1);
      send_one(REQ_READ, 48'h80, 1'b0, 1'b0);
      send_one(REQ_READ, '0, 1'b1, 1'b0);
      send_one(REQ_READ, '1, 1'b1, 1'b1);
      drain();
      // round limit of one: fills then reads one block ahead, too few reads to finish the round
      set_config(2, 1, 12, 1, 31, 0);
      for (int k = 0; k < 4; k++) send_one(REQ_FILL, 48'h1000 + 4 * k, 1'b1, 1'b0);
      for (int k = 0; k < 12; k++) send_one(REQ_READ, 48'h1004 + 4 * k, 1'b1, 1'b0);
      send_one(REQ_FILL, 48'h2000, 1'b0, 1'b1);
      send_one(REQ_READ, 48'h1FFC, 1'b1, 1'b0);
      send_one(REQ_READ, 48'hFFF8, 1'b1, 1'b1);
      drain();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_config(12, 1, 30, 255, 31, 31);
            1: set_config(0, 1, 0, 0, 0, 0);
            2: set_config(15, 0, 31, 2, 1, 0);
            default: set_config($urandom_range(2, 8), $urandom_range(0, 1),
                                 $urandom_range(12, 20), $urandom_range(1, 4),
                                 $urandom_range(2, 31), $urandom_range(0, 3));
         endcase
         if (p == 4) hold_req = 1;
         if (p == 7) quiet = 1;
         random_phase(p < 3 ? 50 : 155);
         drain();
      end

      if (sb.errors == 0 && sb.expected_addrs.size() == 0) begin
         $display("[best_offset_prefetcher] OK");
      end else begin
         if (sb.expected_addrs.size() != 0)
            $error("prefetch_addr expected %h actual none", sb.expected_addrs[0]);
         $display("[best_offset_prefetcher] ERROR");
      end
      $finish;
   end

endmodule
